// File: rtl/fvp_pkg.sv
// Shared types, constants and arithmetic helpers for the fisheye vertex projector.
package fvp_pkg;

  localparam int COORD_W   = 20;
  localparam int SUB_W     = 20;
  localparam int COEF_W    = 16;
  localparam int ROOT_W    = COORD_W;
  localparam int PL2_W     = 2 * COORD_W;
  localparam int CORDIC_N  = 16;
  localparam int CORDIC_SH = 12;
  localparam int CX_W      = COORD_W + 16;
  localparam int ANG_W     = 20;
  localparam int THETA_W   = 17;
  localparam int T2_W      = 18;
  localparam int T4_W      = 19;
  localparam int T6_W      = 20;
  localparam int T8_W      = 22;
  localparam int KP_W      = 40;
  localparam int FAC_W     = 31;
  localparam int TF_W      = THETA_W + 1 + FAC_W;
  localparam int CD_W      = 32;
  localparam int DIV_N     = 32;
  localparam int NUM_W     = ROOT_W + DIV_N;
  localparam int QUO_W     = DIV_N + 1;
  localparam int PU_W      = 32;
  localparam int MU_W      = SUB_W + QUO_W;
  localparam int MU2_W     = PU_W + SUB_W + 1;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  localparam logic signed [ANG_W-1:0]   HALF_PI     = ANG_W'(102944);
  localparam logic signed [COORD_W-1:0] MINUS_ONE   = COORD_W'(-256);
  localparam logic signed [63:0]        NEAR_MARGIN = 64'sd26;
  localparam logic signed [63:0]        ONE_Q16     = 64'sd65536;

  localparam logic [47:0] ROT_X_RST  = 48'h0000_0000_4000;
  localparam logic [47:0] ROT_Y_RST  = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_Z_RST  = 48'h4000_0000_0000;
  localparam logic [59:0] TRANS_RST  = 60'd0;
  localparam logic [63:0] DIST_RST   = 64'd0;
  localparam logic [59:0] INTR_RST   = 60'd72057594037928192;
  localparam logic [59:0] LIMITS_RST = 60'd2814752451461146;

  typedef enum logic [2:0] {
    REG_ROT_X, REG_ROT_Y, REG_ROT_Z, REG_TRANS,
    REG_DIST, REG_INTR_U, REG_INTR_V, REG_LIMITS
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][2:0][COEF_W-1:0] rot;
    logic [2:0][SUB_W-1:0]       tr;
    logic [3:0][COEF_W-1:0]      dcoef;
    logic [SUB_W-1:0]            fx;
    logic [SUB_W-1:0]            cx;
    logic [SUB_W-1:0]            rw;
    logic [SUB_W-1:0]            fy;
    logic [SUB_W-1:0]            cy;
    logic [SUB_W-1:0]            rh;
    logic [SUB_W-1:0]            off;
    logic [SUB_W-1:0]            tw;
    logic [SUB_W-1:0]            th;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] c0;
    logic signed [COORD_W-1:0] c1;
    logic [COORD_W-1:0]        dabs;
    logic [ROOT_W-1:0]         planar;
    logic                      vis;
    logic                      near;
    logic                      axis;
  } side_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] tex_u;
    logic signed [COORD_W-1:0] tex_v;
    logic                      alpha;
  } tex_t;

  // round half up, then arithmetic shift
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                input int unsigned sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                               input int unsigned bits);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [63:0] v);
    return COORD_W'(sat64(v, COORD_W));
  endfunction

endpackage

// File: rtl/fvp_ifs.sv
// Valid/ready channel interfaces for vertex input and texture output.
interface fvp_vtx_if;
  import fvp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] world_x;
  logic signed [COORD_W-1:0] world_y;
  logic signed [COORD_W-1:0] world_z;
  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

interface fvp_tex_if;
  import fvp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] tex_u;
  logic signed [COORD_W-1:0] tex_v;
  logic                      alpha;
  modport source (output valid, tex_u, tex_v, alpha, input ready);
  modport sink (input valid, tex_u, tex_v, alpha, output ready);
endinterface

// File: rtl/fvp_regs.sv
// APB configuration register file for the fisheye vertex projector.
module fvp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fvp_pkg::ADDR_W-1:0]    paddr,
  input  logic [fvp_pkg::DATA_W-1:0]    pwdata,
  output logic [fvp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output fvp_pkg::cfg_t                 cfg
);
  import fvp_pkg::*;

  logic [47:0] rot_row_x;
  logic [47:0] rot_row_y;
  logic [47:0] rot_row_z;
  logic [59:0] translation;
  logic [63:0] distortion;
  logic [59:0] intrinsic_u;
  logic [59:0] intrinsic_v;
  logic [59:0] view_limits;
  reg_idx_t    idx;
  logic        wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row_x   <= ROT_X_RST;
      rot_row_y   <= ROT_Y_RST;
      rot_row_z   <= ROT_Z_RST;
      translation <= TRANS_RST;
      distortion  <= DIST_RST;
      intrinsic_u <= INTR_RST;
      intrinsic_v <= INTR_RST;
      view_limits <= LIMITS_RST;
    end else if (wr) begin
      case (idx)
        REG_ROT_X:  rot_row_x   <= pwdata[47:0];
        REG_ROT_Y:  rot_row_y   <= pwdata[47:0];
        REG_ROT_Z:  rot_row_z   <= pwdata[47:0];
        REG_TRANS:  translation <= pwdata[59:0];
        REG_DIST:   distortion  <= pwdata;
        REG_INTR_U: intrinsic_u <= pwdata[59:0];
        REG_INTR_V: intrinsic_v <= pwdata[59:0];
        REG_LIMITS: view_limits <= pwdata[59:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROT_X:  prdata = DATA_W'(rot_row_x);
      REG_ROT_Y:  prdata = DATA_W'(rot_row_y);
      REG_ROT_Z:  prdata = DATA_W'(rot_row_z);
      REG_TRANS:  prdata = DATA_W'(translation);
      REG_DIST:   prdata = distortion;
      REG_INTR_U: prdata = DATA_W'(intrinsic_u);
      REG_INTR_V: prdata = DATA_W'(intrinsic_v);
      REG_LIMITS: prdata = DATA_W'(view_limits);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.rot[0] = rot_row_x;
    cfg.rot[1] = rot_row_y;
    cfg.rot[2] = rot_row_z;
    cfg.tr     = translation;
    cfg.dcoef  = distortion;
    cfg.fx     = intrinsic_u[19:0];
    cfg.cx     = intrinsic_u[39:20];
    cfg.rw     = intrinsic_u[59:40];
    cfg.fy     = intrinsic_v[19:0];
    cfg.cy     = intrinsic_v[39:20];
    cfg.rh     = intrinsic_v[59:40];
    cfg.off    = view_limits[19:0];
    cfg.tw     = view_limits[39:20];
    cfg.th     = view_limits[59:40];
  end

endmodule

// File: rtl/fvp_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module fvp_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [fvp_pkg::PL2_W-1:0]    radicand,
  input  fvp_pkg::side_t               in_side,
  output logic                         out_valid,
  output fvp_pkg::side_t               out_side
);
  import fvp_pkg::*;

  logic [ROOT_W:0]   vld;
  logic [ROOT_W+1:0] rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  logic [PL2_W-1:0]  rad_q  [ROOT_W+1];
  side_t             side_q [ROOT_W+1];
  logic [ROOT_W+3:0] acc    [ROOT_W];
  logic [ROOT_W+3:0] trial  [ROOT_W];
  logic [ROOT_W+3:0] diff   [ROOT_W];

  always_comb begin
    for (int s = 0; s < ROOT_W; s++) begin
      acc[s]   = {rem_q[s], rad_q[s][PL2_W-1 -: 2]};
      trial[s] = {2'b00, root_q[s], 2'b01};
      diff[s]  = acc[s] - trial[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      rad_q[0]  <= radicand;
      side_q[0] <= in_side;
      for (int s = 0; s < ROOT_W; s++) begin
        if (acc[s] >= trial[s]) begin
          rem_q[s+1]  <= diff[s][ROOT_W+1:0];
          root_q[s+1] <= {root_q[s][ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[s+1]  <= acc[s][ROOT_W+1:0];
          root_q[s+1] <= {root_q[s][ROOT_W-2:0], 1'b0};
        end
        rad_q[s+1]  <= rad_q[s] << 2;
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign out_valid = vld[ROOT_W];

  always_comb begin
    out_side        = side_q[ROOT_W];
    out_side.planar = root_q[ROOT_W];
  end

endmodule

// File: rtl/fvp_cordic.sv
// Pipelined CORDIC vectoring stages producing the off-axis angle.
module fvp_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  fvp_pkg::side_t                    in_side,
  output logic                              out_valid,
  output logic signed [fvp_pkg::ANG_W-1:0]  angle,
  output fvp_pkg::side_t                    out_side
);
  import fvp_pkg::*;

  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0:    return ANG_W'(51472);
      4'd1:    return ANG_W'(30385);
      4'd2:    return ANG_W'(16055);
      4'd3:    return ANG_W'(8150);
      4'd4:    return ANG_W'(4091);
      4'd5:    return ANG_W'(2047);
      4'd6:    return ANG_W'(1024);
      4'd7:    return ANG_W'(512);
      4'd8:    return ANG_W'(256);
      4'd9:    return ANG_W'(128);
      4'd10:   return ANG_W'(64);
      4'd11:   return ANG_W'(32);
      4'd12:   return ANG_W'(16);
      4'd13:   return ANG_W'(8);
      4'd14:   return ANG_W'(4);
      default: return ANG_W'(2);
    endcase
  endfunction

  logic [CORDIC_N:0]        vld;
  logic signed [CX_W-1:0]   x_q [CORDIC_N+1];
  logic signed [CX_W-1:0]   y_q [CORDIC_N+1];
  logic signed [ANG_W-1:0]  z_q [CORDIC_N+1];
  side_t                    side_q [CORDIC_N+1];
  logic signed [CX_W-1:0]   dx [CORDIC_N];
  logic signed [CX_W-1:0]   dy [CORDIC_N];

  always_comb begin
    for (int s = 0; s < CORDIC_N; s++) begin
      dx[s] = x_q[s] >>> s;
      dy[s] = y_q[s] >>> s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[CORDIC_N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0]    <= $signed(CX_W'({in_side.dabs, CORDIC_SH'(0)}));
      y_q[0]    <= $signed(CX_W'({in_side.planar, CORDIC_SH'(0)}));
      z_q[0]    <= '0;
      side_q[0] <= in_side;
      for (int s = 0; s < CORDIC_N; s++) begin
        if (y_q[s] > 0) begin
          x_q[s+1] <= x_q[s] + dy[s];
          y_q[s+1] <= y_q[s] - dx[s];
          z_q[s+1] <= z_q[s] + atan_q16(4'(s));
        end else begin
          x_q[s+1] <= x_q[s] - dy[s];
          y_q[s+1] <= y_q[s] + dx[s];
          z_q[s+1] <= z_q[s] - atan_q16(4'(s));
        end
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign out_valid = vld[CORDIC_N];
  assign angle     = z_q[CORDIC_N];
  assign out_side  = side_q[CORDIC_N];

endmodule

// File: rtl/fvp_div.sv
// Two-lane pipelined restoring divider, signed dividend, quotient truncated to zero.
module fvp_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [1:0][fvp_pkg::NUM_W-1:0]      num,
  input  fvp_pkg::side_t                      in_side,
  output logic                                out_valid,
  output logic [1:0][fvp_pkg::QUO_W-1:0]      quo,
  output fvp_pkg::side_t                      out_side
);
  import fvp_pkg::*;

  logic [DIV_N+1:0]  vld;
  logic [NUM_W-1:0]  mag0  [2];
  logic [ROOT_W-1:0] rem_q [2][DIV_N+1];
  logic [DIV_N-1:0]  low_q [2][DIV_N+1];
  logic [DIV_N-1:0]  q_q   [2][DIV_N+1];
  logic              neg_q [2][DIV_N+1];
  side_t             side_q [DIV_N+1];
  logic [ROOT_W:0]   tmp   [2][DIV_N];
  logic [ROOT_W:0]   diff  [2][DIV_N];
  logic              ge    [2][DIV_N];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag0[l] = num[l][NUM_W-1] ? (~num[l] + 1'b1) : num[l];
      for (int s = 0; s < DIV_N; s++) begin
        tmp[l][s]  = {rem_q[l][s], low_q[l][s][DIV_N-1]};
        ge[l][s]   = tmp[l][s] >= {1'b0, side_q[s].planar};
        diff[l][s] = tmp[l][s] - {1'b0, side_q[s].planar};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_N:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= in_side;
      for (int s = 0; s < DIV_N; s++) begin
        side_q[s+1] <= side_q[s];
      end
      out_side <= side_q[DIV_N];
      for (int l = 0; l < 2; l++) begin
        rem_q[l][0] <= mag0[l][NUM_W-1 -: ROOT_W];
        low_q[l][0] <= mag0[l][DIV_N-1:0];
        q_q[l][0]   <= '0;
        neg_q[l][0] <= num[l][NUM_W-1];
        for (int s = 0; s < DIV_N; s++) begin
          rem_q[l][s+1] <= ge[l][s] ? diff[l][s][ROOT_W-1:0] : tmp[l][s][ROOT_W-1:0];
          low_q[l][s+1] <= low_q[l][s] << 1;
          q_q[l][s+1]   <= {q_q[l][s][DIV_N-2:0], ge[l][s]};
          neg_q[l][s+1] <= neg_q[l][s];
        end
        quo[l] <= neg_q[l][DIV_N] ? (QUO_W'(0) - {1'b0, q_q[l][DIV_N]})
                                  : {1'b0, q_q[l][DIV_N]};
      end
    end
  end

  assign out_valid = vld[DIV_N+1];

endmodule

// File: rtl/fisheye_vertex_projection.sv
// Top level: fisheye vertex projection pipeline with APB configuration.
//
//  channel | dir | handshake             | payload
//  vtx     | in  | valid/ready           | world_x, world_y, world_z
//  tex     | out | valid/ready           | tex_u, tex_v, alpha
//  apb     | in  | psel/penable/pready   | paddr, pwdata, prdata
//
// One item per cycle sustained while the skid register is empty; the path from accept to result runs
// through 4 front stages, square root (21 stages), CORDIC (17), polynomial (8),
// divider (34), focal/window stages (3) and the output register.
// rst is synchronous and clears all valid bits and the output/skid state.
// A stall freezes every stage at once; a skid register behind the output register
// takes the item in flight, so vtx.ready is registered and never waits on tex.ready.
module fisheye_vertex_projection (
  input  logic                          clk,
  input  logic                          rst,
  fvp_vtx_if.sink                       vtx,
  fvp_tex_if.source                     tex,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fvp_pkg::ADDR_W-1:0]    paddr,
  input  logic [fvp_pkg::DATA_W-1:0]    pwdata,
  output logic [fvp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import fvp_pkg::*;

  cfg_t cfg;
  logic en;

  fvp_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // rotation and translation
  logic                            v1, v2, v3, v4;
  logic signed [COORD_W-1:0]       p [3];
  logic signed [COEF_W+COORD_W-1:0] prod1 [3][3];
  logic signed [COEF_W+COORD_W+1:0] acc2 [3];
  logic signed [COORD_W-1:0]       c2 [3];
  logic signed [2*COORD_W-1:0]     sq0_3, sq1_3;
  side_t                           side3, side4, side3_ax;
  logic [PL2_W-1:0]                pl2_4;

  assign p[0] = vtx.world_z;
  assign p[1] = vtx.world_x;
  assign p[2] = vtx.world_y;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc2[i] = (COEF_W+COORD_W+2)'(prod1[i][0]) + (COEF_W+COORD_W+2)'(prod1[i][1])
              + (COEF_W+COORD_W+2)'(prod1[i][2]);
    end
  end

  always_comb begin
    side3_ax      = side3;
    side3_ax.axis = (sq0_3 == '0) && (sq1_3 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= vtx.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod1[i][j] <= $signed(cfg.rot[i][j]) * p[j];
        end
        c2[i] <= sat_coord(rnd_sh(64'(acc2[i]), 14) + 64'($signed(cfg.tr[i])));
      end
      sq0_3        <= c2[0] * c2[0];
      sq1_3        <= c2[1] * c2[1];
      side3.c0     <= c2[0];
      side3.c1     <= c2[1];
      side3.dabs   <= COORD_W'(c2[2][COORD_W-1] ? -(COORD_W+1)'(c2[2])
                                                : (COORD_W+1)'(c2[2]));
      side3.planar <= '0;
      side3.vis    <= 64'(c2[2]) > 64'($signed(cfg.off));
      side3.near   <= 64'(c2[2]) > 64'($signed(cfg.off)) + NEAR_MARGIN;
      side3.axis   <= 1'b0;
      pl2_4        <= unsigned'(sq0_3) + unsigned'(sq1_3);
      side4        <= side3_ax;
    end
  end

  // planar length and angle
  logic                      vi, vc;
  side_t                     side_i, side_c;
  logic signed [ANG_W-1:0]   angle_c;

  fvp_isqrt u_isqrt (
    .clk, .rst, .en, .in_valid(v4), .radicand(pl2_4), .in_side(side4),
    .out_valid(vi), .out_side(side_i)
  );

  fvp_cordic u_cordic (
    .clk, .rst, .en, .in_valid(vi), .in_side(side_i),
    .out_valid(vc), .angle(angle_c), .out_side(side_c)
  );

  // distortion polynomial and radius split
  logic [8:1]                 vp;
  side_t                      sp [1:8];
  logic [THETA_W-1:0]         theta_c;
  logic [THETA_W-1:0]         t_p [1:5];
  logic [T2_W-1:0]            t2_p1, t2_p2, t2_p3;
  logic [T4_W-1:0]            t4_p2, t4_p3;
  logic [T6_W-1:0]            t6_p3;
  logic [T8_W-1:0]            t8_p3;
  logic signed [KP_W-1:0]     kp [4];
  logic signed [63:0]         ksum;
  logic signed [FAC_W-1:0]    factor_p5;
  logic signed [TF_W-1:0]     tf_p6;
  logic signed [CD_W-1:0]     cd_p7;
  logic [1:0][NUM_W-1:0]      n_p8;

  always_comb begin
    if (angle_c < 0) begin
      theta_c = '0;
    end else if (angle_c > HALF_PI) begin
      theta_c = THETA_W'(HALF_PI);
    end else begin
      theta_c = angle_c[THETA_W-1:0];
    end
    ksum = 64'(kp[0]) + 64'(kp[1]) + 64'(kp[2]) + 64'(kp[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[7:1], vc};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp[1] <= side_c;
      for (int k = 2; k <= 8; k++) begin
        sp[k] <= sp[k-1];
      end
      t_p[1] <= theta_c;
      for (int k = 2; k <= 5; k++) begin
        t_p[k] <= t_p[k-1];
      end
      t2_p1 <= T2_W'((48'(theta_c) * 48'(theta_c) + 48'd32768) >> 16);
      t2_p2 <= t2_p1;
      t4_p2 <= T4_W'((48'(t2_p1) * 48'(t2_p1) + 48'd32768) >> 16);
      t2_p3 <= t2_p2;
      t4_p3 <= t4_p2;
      t6_p3 <= T6_W'((48'(t4_p2) * 48'(t2_p2) + 48'd32768) >> 16);
      t8_p3 <= T8_W'((48'(t4_p2) * 48'(t4_p2) + 48'd32768) >> 16);
      kp[0] <= $signed(cfg.dcoef[0]) * $signed({1'b0, t2_p3});
      kp[1] <= $signed(cfg.dcoef[1]) * $signed({1'b0, t4_p3});
      kp[2] <= $signed(cfg.dcoef[2]) * $signed({1'b0, t6_p3});
      kp[3] <= $signed(cfg.dcoef[3]) * $signed({1'b0, t8_p3});
      factor_p5 <= FAC_W'(ONE_Q16 + rnd_sh(ksum, 12));
      tf_p6 <= $signed({1'b0, t_p[5]}) * factor_p5;
      cd_p7 <= CD_W'(sat64(rnd_sh(64'(tf_p6), 16), CD_W));
      n_p8[0] <= sp[7].c0 * cd_p7;
      n_p8[1] <= sp[7].c1 * cd_p7;
    end
  end

  logic                   vd;
  logic [1:0][QUO_W-1:0]  quo_d;
  side_t                  side_d;

  fvp_div u_div (
    .clk, .rst, .en, .in_valid(vp[8]), .num(n_p8), .in_side(sp[8]),
    .out_valid(vd), .quo(quo_d), .out_side(side_d)
  );

  // focal scale, centre, texture window and reciprocal size
  logic [3:1]              vq;
  side_t                   sq [1:3];
  logic signed [MU_W-1:0]  mu_q1, mv_q1;
  logic signed [PU_W-1:0]  pu_q2, pv_q2;
  logic signed [MU2_W-1:0] mu2_q3, mv2_q3;
  logic                    inside_q3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (en) begin
      vq <= {vq[2:1], vd};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[1] <= side_d;
      sq[2] <= sq[1];
      sq[3] <= sq[2];
      mu_q1 <= $signed(cfg.fx) * $signed(quo_d[0]);
      mv_q1 <= $signed(cfg.fy) * $signed(quo_d[1]);
      pu_q2 <= sq[1].axis ? PU_W'($signed(cfg.cx))
             : PU_W'(sat64(rnd_sh(64'(mu_q1), 16) + 64'($signed(cfg.cx)), PU_W));
      pv_q2 <= sq[1].axis ? PU_W'($signed(cfg.cy))
             : PU_W'(sat64(rnd_sh(64'(mv_q1), 16) + 64'($signed(cfg.cy)), PU_W));
      inside_q3 <= sq[2].vis && !pu_q2[PU_W-1] && !pv_q2[PU_W-1]
                && (64'(pu_q2) <= 64'($signed(cfg.tw)))
                && (64'(pv_q2) <= 64'($signed(cfg.th)));
      mu2_q3 <= pu_q2 * $signed({1'b0, cfg.rw});
      mv2_q3 <= pv_q2 * $signed({1'b0, cfg.rh});
    end
  end

  // output register with skid
  tex_t res, od, skid;
  logic ov, skid_full, push;

  always_comb begin
    if (inside_q3) begin
      res.tex_u = sat_coord(rnd_sh(64'(mu2_q3), 16));
      res.tex_v = sat_coord(rnd_sh(64'(mv2_q3), 16));
      res.alpha = sq[3].near;
    end else begin
      res.tex_u = MINUS_ONE;
      res.tex_v = MINUS_ONE;
      res.alpha = 1'b0;
    end
  end

  assign en        = !skid_full;
  assign push      = en & vq[3];
  assign vtx.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov        <= 1'b0;
      skid_full <= 1'b0;
    end else if (!ov || tex.ready) begin
      if (skid_full) begin
        ov        <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        ov <= push;
      end
    end else if (push) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || tex.ready) begin
      od <= skid_full ? skid : res;
    end else if (push) begin
      skid <= res;
    end
  end

  assign tex.valid = ov;
  assign tex.tex_u = od.tex_u;
  assign tex.tex_v = od.tex_v;
  assign tex.alpha = od.alpha;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> ov) else $error("skid holds an item while output is empty");

  a_skid_blocks_in: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> !vtx.ready) else $error("input open while skid is full");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vq[3] && !en) |=> vq[3]) else $error("last stage item dropped during stall");

  a_alpha_nonneg: assert property (@(posedge clk) disable iff (rst)
    (ov && tex.alpha) |-> (!tex.tex_u[COORD_W-1] && !tex.tex_v[COORD_W-1]))
    else $error("visible item with negative texture coordinate");
`endif

endmodule

// File: test/tb_fisheye_vertex_projection.sv
// Self-checking testbench for the fisheye vertex projector: random vertices, APB setup, scoreboard.
module tb_fisheye_vertex_projection;
  import fvp_pkg::*;

  localparam int WATCHDOG = 5000;
  localparam int DRAIN = 100;
  localparam int LONG_HOLD = 300;
  localparam longint ATAN_TAB [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2};

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  fvp_vtx_if vtx();
  fvp_tex_if tex();

  fisheye_vertex_projection u_top (
    .clk(clk), .rst(rst), .vtx(vtx), .tex(tex),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [63:0] cam_regs [8];
  vertex_t vertex_q [$];
  tex_t texel_q [$];
  int src_gap;
  int sink_stall;
  bit no_idle;
  int long_holds_asked;
  int long_holds_done;
  int mismatches;
  int idle_cycles;
  bit apb_busy;

  always #1 clk = ~clk;

  function automatic longint round_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint view_angle(longint d, longint pl);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = d * 4096;
    y = pl * 4096;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y > 0) begin
        x = x + dy; y = y - dx; z = z + ATAN_TAB[i];
      end else begin
        x = x - dy; y = y + dx; z = z - ATAN_TAB[i];
      end
    end
    return z < 0 ? 0 : (z > 102944 ? 102944 : z);
  endfunction

  function automatic tex_t project_vertex(vertex_t vin);
    longint p [3];
    longint c [3];
    longint acc;
    longint off, tw, th, fx, cx, rw, fy, cy, rh;
    longint pl, t, t2, t4, t6, t8, sum, fac, cd, xd, yd, pu, pv;
    longint unsigned pl2;
    logic [63:0] row;
    logic [63:0] dk;
    tex_t r;
    p[0] = vin.z;
    p[1] = vin.x;
    p[2] = vin.y;
    for (int i = 0; i < 3; i++) begin
      row = cam_regs[i];
      acc = 0;
      for (int j = 0; j < 3; j++) acc += $signed(row[16*j +: 16]) * p[j];
      c[i] = clip(round_sh(acc, 14) + $signed(cam_regs[REG_TRANS][20*i +: 20]), COORD_W);
    end
    off = $signed(cam_regs[REG_LIMITS][19:0]);
    tw = $signed(cam_regs[REG_LIMITS][39:20]);
    th = $signed(cam_regs[REG_LIMITS][59:40]);
    r.tex_u = MINUS_ONE;
    r.tex_v = MINUS_ONE;
    r.alpha = 1'b0;
    if (c[2] > off) begin
      fx = $signed(cam_regs[REG_INTR_U][19:0]);
      cx = $signed(cam_regs[REG_INTR_U][39:20]);
      rw = cam_regs[REG_INTR_U][59:40];
      fy = $signed(cam_regs[REG_INTR_V][19:0]);
      cy = $signed(cam_regs[REG_INTR_V][39:20]);
      rh = cam_regs[REG_INTR_V][59:40];
      pl2 = c[0] * c[0] + c[1] * c[1];
      pu = cx;
      pv = cy;
      if (pl2 != 0) begin
        dk = cam_regs[REG_DIST];
        pl = int_root(pl2);
        t = view_angle(c[2] < 0 ? -c[2] : c[2], pl);
        t2 = round_sh(t * t, 16);
        t4 = round_sh(t2 * t2, 16);
        t6 = round_sh(t4 * t2, 16);
        t8 = round_sh(t4 * t4, 16);
        sum = $signed(dk[15:0]) * t2 + $signed(dk[31:16]) * t4
            + $signed(dk[47:32]) * t6 + $signed(dk[63:48]) * t8;
        fac = 65536 + round_sh(sum, 12);
        cd = clip(round_sh(t * fac, 16), 32);
        xd = (c[0] * cd) / pl;
        yd = (c[1] * cd) / pl;
        pu = clip(round_sh(fx * xd, 16) + cx, 32);
        pv = clip(round_sh(fy * yd, 16) + cy, 32);
      end
      if (pv >= 0 && pv <= th && pu >= 0 && pu <= tw) begin
        r.tex_u = COORD_W'(clip(round_sh(pu * rw, 16), COORD_W));
        r.tex_v = COORD_W'(clip(round_sh(pv * rh, 16), COORD_W));
        r.alpha = c[2] > off + 26;
      end
    end
    return r;
  endfunction

  // vertex source
  always @(posedge clk) begin
    vertex_t it;
    if (rst) begin
      vtx.valid <= 1'b0;
      src_gap <= 0;
    end else if (!vtx.valid || vtx.ready) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        vtx.valid <= 1'b0;
      end else if (vertex_q.size() > 0) begin
        it = vertex_q.pop_front();
        vtx.world_x <= it.x;
        vtx.world_y <= it.y;
        vtx.world_z <= it.z;
        vtx.valid <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 4);
      end else begin
        vtx.valid <= 1'b0;
      end
    end
  end

  // texel sink with random and long stalls
  always @(posedge clk) begin
    if (rst) begin
      tex.ready <= 1'b0;
      sink_stall <= 0;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      tex.ready <= 1'b0;
    end else if (long_holds_done < long_holds_asked) begin
      long_holds_done <= long_holds_done + 1;
      sink_stall <= LONG_HOLD - 1;
      tex.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      sink_stall <= $urandom_range(0, 3);
      tex.ready <= 1'b0;
    end else begin
      tex.ready <= 1'b1;
    end
  end

  // predict on accept, check on result, watchdog
  always @(posedge clk) begin
    vertex_t vin;
    tex_t want;
    if (!rst) begin
      if (vtx.valid && vtx.ready) begin
        vin.x = vtx.world_x;
        vin.y = vtx.world_y;
        vin.z = vtx.world_z;
        texel_q.insert(texel_q.size(), project_vertex(vin));
      end
      if (tex.valid && tex.ready) begin
        if (texel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: u=%0d v=%0d a=%0d", tex.tex_u, tex.tex_v, tex.alpha);
        end else begin
          want = texel_q.pop_front();
          if (tex.tex_u !== want.tex_u || tex.tex_v !== want.tex_v
              || tex.alpha !== want.alpha) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp u=%0d v=%0d a=%0d got u=%0d v=%0d a=%0d",
                       want.tex_u, want.tex_v, want.alpha, tex.tex_u, tex.tex_v, tex.alpha);
          end
        end
      end
      if ((vtx.valid && vtx.ready) || (tex.valid && tex.ready) || apb_busy) idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG) begin
        $display("== FAIL ==");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [63:0] val);
    apb_busy = 1'b1;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(int'(idx) * 8);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ROT_X, REG_ROT_Y, REG_ROT_Z: cam_regs[idx] = val & 64'hFFFF_FFFF_FFFF;
      REG_DIST: cam_regs[idx] = val;
      default: cam_regs[idx] = val & 64'h0FFF_FFFF_FFFF_FFFF;
    endcase
    apb_busy = 1'b0;
  endtask

  task automatic wait_drained();
    while (vertex_q.size() != 0 || texel_q.size() != 0 || vtx.valid) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    int d;
    if ($urandom_range(0, 4) < 3) begin
      d = $urandom_range(256, 200000);
      v.y = COORD_W'(d);
      v.x = COORD_W'(int'($urandom_range(0, 2 * d)) - d);
      v.z = COORD_W'(int'($urandom_range(0, 2 * d)) - d);
    end else begin
      v.x = COORD_W'($urandom);
      v.y = COORD_W'($urandom);
      v.z = COORD_W'($urandom);
    end
    return v;
  endfunction

  task automatic add_vertex(int x, int y, int z);
    vertex_t v;
    v.x = COORD_W'(x);
    v.y = COORD_W'(y);
    v.z = COORD_W'(z);
    vertex_q.insert(vertex_q.size(), v);
  endtask

  task automatic add_random(int n);
    repeat (n) vertex_q.insert(vertex_q.size(), rand_vertex());
  endtask

  task automatic camera_setup(logic [63:0] k_set);
    reg_write(REG_ROT_X, ROT_X_RST);
    reg_write(REG_ROT_Y, ROT_Y_RST);
    reg_write(REG_ROT_Z, ROT_Z_RST);
    reg_write(REG_TRANS, {4'd0, 20'sd512, 20'sd0, -20'sd256});
    reg_write(REG_DIST, k_set);
    reg_write(REG_INTR_U, {4'd0, 20'd34, 20'd245760, 20'd153600});
    reg_write(REG_INTR_V, {4'd0, 20'd61, 20'd138240, 20'd153600});
    reg_write(REG_LIMITS, {4'd0, 20'd276480, 20'd491520, 20'd26});
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    vtx.valid = 1'b0;
    vtx.world_x = '0;
    vtx.world_y = '0;
    vtx.world_z = '0;
    tex.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    no_idle = 1'b0;
    apb_busy = 1'b0;
    long_holds_asked = 0;
    long_holds_done = 0;
    mismatches = 0;
    idle_cycles = 0;
    cam_regs[REG_ROT_X] = ROT_X_RST;
    cam_regs[REG_ROT_Y] = ROT_Y_RST;
    cam_regs[REG_ROT_Z] = ROT_Z_RST;
    cam_regs[REG_TRANS] = TRANS_RST;
    cam_regs[REG_DIST] = DIST_RST;
    cam_regs[REG_INTR_U] = INTR_RST;
    cam_regs[REG_INTR_V] = INTR_RST;
    cam_regs[REG_LIMITS] = LIMITS_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed, reset setup: depth is world_y
    add_vertex(0, 1000, 0);            // on the axis
    add_vertex(0, 0, 0);               // behind the near plane
    add_vertex(0, 26, 0);
    add_vertex(0, 27, 0);              // just in front, alpha off
    add_vertex(0, 53, 0);              // alpha on
    add_vertex(100, -5000, 100);       // behind
    add_vertex(524287, 524287, 524287);
    add_vertex(-524288, -524288, -524288);
    add_vertex(-524288, 524287, 524287);
    add_vertex(524287, 524287, -524288);
    add_vertex(1, 524287, 1);
    add_vertex(256, 256, 256);
    add_vertex(256, 2560, 0);
    add_vertex(0, 2560, 256);
    add_vertex(-256, 2560, -256);
    add_vertex(524287, 1, 524287);     // wide angle
    add_vertex(-1, -1, -1);
    add_vertex(5000, 200, 5000);
    add_random(180);
    wait_drained();

    camera_setup({16'sd20, -16'sd40, 16'sd60, -16'sd200});
    add_vertex(0, 1000, 0);
    add_vertex(0, 26, 0);
    add_vertex(0, 27, 0);
    add_random(180);
    wait_drained();

    reg_write(REG_DIST, {4{16'h7FFF}});
    add_random(180);
    long_holds_asked = 1;
    wait_drained();

    reg_write(REG_DIST, {4{16'h8000}});
    reg_write(REG_TRANS, {20'h80000, 20'h7FFFF, 20'h80000});
    reg_write(REG_ROT_X, rand64());
    reg_write(REG_ROT_Y, rand64());
    reg_write(REG_ROT_Z, rand64());
    add_random(180);
    wait_drained();

    for (int i = 0; i < 8; i++) reg_write(reg_idx_t'(i), rand64());
    add_random(180);
    wait_drained();

    for (int i = 0; i < 8; i++) reg_write(reg_idx_t'(i), '1);
    add_random(90);
    wait_drained();

    for (int i = 0; i < 8; i++) reg_write(reg_idx_t'(i), '0);
    add_random(60);
    wait_drained();

    camera_setup({16'sd0, 16'sd100, -16'sd80, 16'sd300});
    no_idle = 1'b1;
    add_random(180);
    wait_drained();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
